[rtl/fia_pkg.sv]
// Shared types and constants for the FIFO identifier allocator.
package fia_pkg;

	localparam int DEF_ID_WIDTH     = 16;
	localparam int DEF_RETURN_DEPTH = 256;
	localparam int BATCH_STEP       = 100;

	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_RETURN  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_DROPPED   = 2'd2
	} status_t;

	typedef struct packed {
		logic    load;
		logic    push;
		logic    pop;
		logic    fresh;
		logic    extend;
		status_t code;
	} cmd_t;

	typedef struct packed {
		logic queue_full;
		logic queue_empty;
		logic fresh_avail;
		logic can_extend;
	} stat_t;

endpackage

[rtl/fia_if.sv]
// Request and response channel interfaces of the identifier allocator.
interface fia_req_if #(
	parameter int ID_WIDTH = fia_pkg::DEF_ID_WIDTH
);
	logic                valid;
	logic                ready;
	logic                kind;
	logic [ID_WIDTH-1:0] id_in;

	modport source (output valid, output kind, output id_in, input ready);
	modport sink (input valid, input kind, input id_in, output ready);
endinterface

interface fia_rsp_if #(
	parameter int ID_WIDTH = fia_pkg::DEF_ID_WIDTH
);
	logic                valid;
	logic                ready;
	logic [ID_WIDTH-1:0] id_out;
	logic [ID_WIDTH-1:0] max_id;
	logic [1:0]          status;

	modport source (output valid, output id_out, output max_id, output status, input ready);
	modport sink (input valid, input id_out, input max_id, input status, output ready);
endinterface

[rtl/fia_ctrl.sv]
// Allocator controller: handshake sequencing and operation decode.
module fia_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          kind,
	input  logic          out_ready,
	input  fia_pkg::stat_t stat,
	output logic          in_ready,
	output logic          out_valid,
	output fia_pkg::cmd_t cmd
);
	import fia_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_BUSY
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;
	logic   accept;

	assign accept    = in_valid && in_ready_q;
	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q     <= S_BUSY;
						in_ready_q  <= 1'b0;
						out_valid_q <= 1'b1;
					end
				end
				S_BUSY: begin
					if (out_ready) begin
						state_q     <= S_IDLE;
						in_ready_q  <= 1'b1;
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q     <= S_IDLE;
					in_ready_q  <= 1'b1;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		cmd      = '0;
		cmd.code = ST_OK;
		cmd.load = accept;
		if (accept) begin
			if (kind == KIND_RETURN) begin
				if (stat.queue_full) begin
					cmd.code = ST_DROPPED;
				end else begin
					cmd.push = 1'b1;
				end
			end else begin
				priority if (stat.fresh_avail) begin
					cmd.fresh = 1'b1;
				end else if (!stat.queue_empty) begin
					cmd.pop = 1'b1;
				end else if (stat.can_extend) begin
					cmd.extend = 1'b1;
				end else begin
					cmd.code = ST_EXHAUSTED;
				end
			end
		end
	end
endmodule

[rtl/fia_datapath.sv]
// Allocator datapath: fresh counter, batch end, return queue and result registers.
module fia_datapath #(
	parameter int ID_WIDTH     = fia_pkg::DEF_ID_WIDTH,
	parameter int RETURN_DEPTH = fia_pkg::DEF_RETURN_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fia_pkg::cmd_t       cmd,
	input  logic [ID_WIDTH-1:0] id_in,
	output fia_pkg::stat_t      stat,
	output logic [ID_WIDTH-1:0] id_out,
	output logic [ID_WIDTH-1:0] max_id,
	output logic [1:0]          status
);
	import fia_pkg::*;

	localparam int IDX_W = $clog2(RETURN_DEPTH);
	localparam int CNT_W = $clog2(RETURN_DEPTH + 1);

	logic [ID_WIDTH-1:0] fresh_q;
	logic [ID_WIDTH-1:0] batch_q;
	logic [IDX_W-1:0]    head_q;
	logic [IDX_W-1:0]    tail_q;
	logic [CNT_W-1:0]    count_q;
	logic [ID_WIDTH-1:0] mem [RETURN_DEPTH];
	logic [ID_WIDTH-1:0] id_out_q;
	status_t             status_q;
	logic [ID_WIDTH:0]   batch_sum;

	assign batch_sum = {1'b0, batch_q} + (ID_WIDTH+1)'(BATCH_STEP);

	assign stat.queue_full  = (count_q == CNT_W'(RETURN_DEPTH));
	assign stat.queue_empty = (count_q == '0);
	assign stat.fresh_avail = (fresh_q <= batch_q);
	assign stat.can_extend  = !batch_sum[ID_WIDTH];

	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] slot);
		return (slot == IDX_W'(RETURN_DEPTH - 1)) ? '0 : slot + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= '0;
			batch_q <= ID_WIDTH'(BATCH_STEP);
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.fresh || cmd.extend) begin
				fresh_q <= fresh_q + 1'b1;
			end
			if (cmd.extend) begin
				batch_q <= batch_sum[ID_WIDTH-1:0];
			end
			if (cmd.push) begin
				tail_q  <= next_slot(tail_q);
				count_q <= count_q + 1'b1;
			end
			if (cmd.pop) begin
				head_q  <= next_slot(head_q);
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[tail_q] <= id_in;
		end
		if (cmd.pop) begin
			id_out_q <= mem[head_q];
		end else if (cmd.load) begin
			id_out_q <= (cmd.fresh || cmd.extend) ? fresh_q : '0;
		end
		if (cmd.load) begin
			status_q <= cmd.code;
		end
	end

	assign id_out = id_out_q;
	assign max_id = batch_q;
	assign status = status_q;
endmodule

[rtl/fifo_id_allocator_unit.sv]
// Top level of the FIFO identifier allocator.
//
//   channel | modport | payload                 | item
//   req     | sink    | kind, id_in             | one request or return
//   rsp     | source  | id_out, max_id, status  | one result per req item
//
// An item is accepted, its result is shown in the next cycle from the output
// registers, and the next item is accepted in the cycle after the result is
// taken. The single-item controller takes no new item while a result is
// pending, so items never overlap.
// Reset starts the fresh batch at 0..100 with an empty queue; no clearing pass.
// A stall on rsp holds the result and keeps req not ready.
module fifo_id_allocator_unit #(
	parameter int ID_WIDTH     = fia_pkg::DEF_ID_WIDTH,
	parameter int RETURN_DEPTH = fia_pkg::DEF_RETURN_DEPTH
) (
	input logic       clk,
	input logic       arst_n,
	fia_req_if.sink   req,
	fia_rsp_if.source rsp
);
	import fia_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	fia_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.kind      (req.kind),
		.out_ready (rsp.ready),
		.stat      (stat),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.cmd       (cmd)
	);

	fia_datapath #(
		.ID_WIDTH     (ID_WIDTH),
		.RETURN_DEPTH (RETURN_DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.id_in  (req.id_in),
		.stat   (stat),
		.id_out (rsp.id_out),
		.max_id (rsp.max_id),
		.status (rsp.status)
	);
endmodule

[rtl/fia_checker.sv]
// Port-level assertions for the identifier allocator, bound to the top level.
module fia_checker #(
	parameter int ID_WIDTH = fia_pkg::DEF_ID_WIDTH
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [ID_WIDTH-1:0] id_out,
	input logic [ID_WIDTH-1:0] max_id,
	input logic [1:0]          status
);
	import fia_pkg::*;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no result after accepted item");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("item accepted while result pending");

	a_no_grant_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EXHAUSTED || status == ST_DROPPED) |-> id_out == '0)
		else $error("identifier granted with error status");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(id_out) && $stable(max_id)
			&& $stable(status))
		else $error("stalled result changed");
endmodule

bind fifo_id_allocator_unit fia_checker #(
	.ID_WIDTH (ID_WIDTH)
) u_fia_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.id_out    (rsp.id_out),
	.max_id    (rsp.max_id),
	.status    (rsp.status)
);

[bench/tb_fifo_id_allocator_unit.sv]
`timescale 1ns / 1ps
// Self-checking bench for the FIFO identifier allocator: predicted grants versus rsp items.
module tb_fifo_id_allocator_unit;
	import fia_pkg::*;

	localparam int ID_W        = DEF_ID_WIDTH;
	localparam int DEPTH       = DEF_RETURN_DEPTH;
	localparam longint ID_MAX  = (64'd1 << ID_W) - 1;
	localparam int CYCLE_LIMIT = 100000;
	localparam int STALL_LEN   = 250;

	typedef struct {
		logic [ID_W-1:0] id_out;
		logic [ID_W-1:0] max_id;
		status_t         status;
	} grant_t;

	logic clk;
	logic arst_n;

	fia_req_if #(.ID_WIDTH(ID_W)) req_ch ();
	fia_rsp_if #(.ID_WIDTH(ID_W)) rsp_ch ();

	fifo_id_allocator_unit #(
		.ID_WIDTH(ID_W),
		.RETURN_DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// allocator state as predicted
	longint unsigned fresh_id;
	longint unsigned batch_top;
	logic [ID_W-1:0] returned_ids[$];

	grant_t  expected_grants[$];
	int      items_sent;
	int      grants_checked;
	int      mismatches;
	int      cycles;
	bit      idle_en;
	int      stall_asks;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: timeout, %0d results still pending", $realtime, expected_grants.size());
		$display("Regression FAIL");
		$finish;
	end

	function automatic grant_t predict_grant(input logic k, input logic [ID_W-1:0] id);
		grant_t g;
		g.id_out = '0;
		g.status = ST_OK;
		if (k == KIND_RETURN) begin
			if (returned_ids.size() >= DEPTH)
				g.status = ST_DROPPED;
			else
				returned_ids.push_back(id);
		end else if (fresh_id <= batch_top) begin
			g.id_out = ID_W'(fresh_id);
			fresh_id++;
		end else if (returned_ids.size() > 0) begin
			g.id_out = returned_ids.pop_front();
		end else if (batch_top + BATCH_STEP > ID_MAX) begin
			g.status = ST_EXHAUSTED;
		end else begin
			batch_top += BATCH_STEP;
			g.id_out = ID_W'(fresh_id);
			fresh_id++;
		end
		g.max_id = ID_W'(batch_top);
		return g;
	endfunction

	task automatic send_item(input logic k, input logic [ID_W-1:0] id);
		grant_t g;
		while (idle_en && $urandom_range(0, 99) < 36) begin
			req_ch.valid <= 1'b0;
			req_ch.kind  <= 1'($urandom);
			req_ch.id_in <= ID_W'($urandom);
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind  <= k;
		req_ch.id_in <= id;
		@(negedge clk);
		while (!req_ch.ready)
			@(negedge clk);
		g = predict_grant(k, id);
		expected_grants.push_back(g);
		items_sent++;
		@(posedge clk);
	endtask

	// receiver: random ready, plus a long hold-off on request
	initial begin
		int stall_seen;
		int stall_left;
		stall_seen = 0;
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_seen != stall_asks) begin
				stall_seen = stall_asks;
				stall_left = STALL_LEN;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= !(idle_en && $urandom_range(0, 99) < 36);
			end
		end
	end

	// checker: sampled mid-cycle, accepted at the following edge
	always @(negedge clk) begin
		grant_t e;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_grants.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected item id_out %0d max_id %0d status %0d", $realtime,
					rsp_ch.id_out, rsp_ch.max_id, rsp_ch.status);
			end else begin
				e = expected_grants.pop_front();
				grants_checked++;
				if (rsp_ch.id_out !== e.id_out || rsp_ch.max_id !== e.max_id ||
						rsp_ch.status !== e.status) begin
					mismatches++;
					$display("%0t: mismatch id_out exp %0d got %0d, max_id exp %0d got %0d, %s",
						$realtime, e.id_out, rsp_ch.id_out, e.max_id, rsp_ch.max_id,
						$sformatf("status exp %0d got %0d", e.status, rsp_ch.status));
				end
			end
		end
	end

	task automatic test_fresh_then_returns();
		send_item(KIND_REQUEST, '0);
		send_item(KIND_REQUEST, '1);
		send_item(KIND_REQUEST, 16'h1234);
		send_item(KIND_RETURN, 16'h0000);
		send_item(KIND_RETURN, 16'hFFFF);
		send_item(KIND_RETURN, 16'hAAAA);
		send_item(KIND_RETURN, 16'h5555);
		send_item(KIND_RETURN, 16'h8000);
		send_item(KIND_RETURN, 16'h0001);
		// fresh batch still served ahead of the queue
		send_item(KIND_REQUEST, '0);
		send_item(KIND_REQUEST, '1);
		send_item(KIND_RETURN, 16'h0003);
	endtask

	task automatic test_batch_rollover();
		int n;
		while (fresh_id <= batch_top)
			send_item(KIND_REQUEST, ID_W'($urandom));
		n = returned_ids.size();
		repeat (n)
			send_item(KIND_REQUEST, ID_W'($urandom));
		// both empty: batch grows by one step
		send_item(KIND_REQUEST, '1);
		send_item(KIND_REQUEST, '0);
	endtask

	task automatic test_random_mix();
		int ret_pct;
		logic [ID_W-1:0] id;
		repeat (6) begin
			case ($urandom_range(0, 2))
				0: begin
					ret_pct = 20;
				end
				1: begin
					ret_pct = 50;
				end
				default: begin
					ret_pct = 80;
				end
			endcase
			repeat (95) begin
				case ($urandom_range(0, 7))
					0: begin
						id = '0;
					end
					1: begin
						id = '1;
					end
					default: begin
						id = ID_W'($urandom);
					end
				endcase
				send_item(($urandom_range(0, 99) < ret_pct) ? KIND_RETURN : KIND_REQUEST, id);
			end
		end
	endtask

	task automatic test_queue_full_under_stall();
		stall_asks++;
		while (returned_ids.size() < DEPTH)
			send_item(KIND_RETURN, ID_W'($urandom));
		repeat (4)
			send_item(KIND_RETURN, ID_W'($urandom));
		repeat (6)
			send_item(KIND_REQUEST, ID_W'($urandom));
		send_item(KIND_RETURN, '1);
		send_item(KIND_RETURN, '0);
	endtask

	task automatic test_no_idle_stretch();
		idle_en = 1'b0;
		repeat (100)
			send_item(1'($urandom), ID_W'($urandom));
		idle_en = 1'b1;
		send_item(KIND_REQUEST, '1);
		send_item(KIND_RETURN, 16'hFFFF);
		send_item(KIND_REQUEST, '0);
		send_item(KIND_REQUEST, '0);
		repeat (20)
			send_item(1'($urandom), ID_W'($urandom));
	endtask

	initial begin
		arst_n       = 1'b0;
		fresh_id     = 0;
		batch_top    = BATCH_STEP;
		items_sent   = 0;
		mismatches   = 0;
		cycles       = 0;
		stall_asks   = 0;
		idle_en      = 1'b1;
		req_ch.valid <= 1'b0;
		req_ch.kind  <= KIND_REQUEST;
		req_ch.id_in <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fresh_then_returns();
		test_batch_rollover();
		test_random_mix();
		test_queue_full_under_stall();
		test_no_idle_stretch();

		req_ch.valid <= 1'b0;
		while (expected_grants.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d items, checked %0d results: fresh grants, queue reuse, batch growth,",
			items_sent, grants_checked);
		$display("full return queue under a long output stall, and a stretch with no idling.");
		if (mismatches == 0 && expected_grants.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
